FILE: sv/xpf_pkg.sv
package xpf_pkg;

    localparam int PAYLOAD_WORDS = 20;
    localparam int GROUP_SIZE    = 2;
    localparam int SLOT_COUNT    = 16;

    localparam int HDR_BYTES     = 12;
    localparam int PACKET_LEN    = HDR_BYTES + 8 * PAYLOAD_WORDS;

    localparam logic [7:0] KIND_DATA   = 8'd0;
    localparam logic [7:0] KIND_PARITY = 8'd1;

    localparam logic [7:0] MAGIC_RESET   = 8'hA7;
    localparam logic [7:0] VERSION_RESET = 8'h01;

    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_VERSION = 1'b1;

    localparam int MEMBERS   = SLOT_COUNT * GROUP_SIZE;
    localparam int MEM_DEPTH = MEMBERS * PAYLOAD_WORDS;
    localparam int PAR_DEPTH = SLOT_COUNT * PAYLOAD_WORDS;

    localparam int PAW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam int BCW = $clog2(PAYLOAD_WORDS + 2);
    localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MIW = $clog2(GROUP_SIZE);
    localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int RAW = (PAR_DEPTH > 1) ? $clog2(PAR_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PLAN,
        ST_CRD,
        ST_CWR,
        ST_RRD,
        ST_RACC,
        ST_RWR
    } t_state;

endpackage

FILE: sv/xor_parity_fec_receiver.sv
// channel | signals                        | transfer when
// --------+--------------------------------+-------------------------------
// in      | i_in_valid / o_in_ready        | both high at rising edge
// out     | o_out_valid / i_out_ready      | both high at rising edge
// cfg     | i_cfg_we, i_cfg_index, data    | i_cfg_we high at rising edge
//
// one input word per cycle while idle; a good last word goes through slot
// setup and planning, then a read and a write per stored or forwarded word and
// reads per member, then a write, per rebuilt word; one read port per store.
// synchronous active-low reset presets config and clears flags and control only.
// a stalled output holds the sequencer; input is not taken until it is done.
module xor_parity_fec_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_wire_length,
    input  logic [7:0]  i_magic_field,
    input  logic [7:0]  i_version_field,
    input  logic [7:0]  i_packet_kind,
    input  logic [7:0]  i_member_index,
    input  logic [7:0]  i_group_size_field,
    input  logic [31:0] i_base_seq,
    input  logic [63:0] i_payload_word,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_frame_seq,
    output logic [63:0] o_frame_word,
    output logic        o_frame_end,
    output logic        o_run_end
);
    import xpf_pkg::*;

    t_state r_state, n_state;

    logic [7:0]  r_magic, n_magic;
    logic [7:0]  r_version, n_version;
    logic [BCW-1:0] r_cnt, n_cnt;
    logic [31:0] r_base, n_base;
    logic        r_is_data, n_is_data;
    logic [MIW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_slot, n_slot;
    logic [31:0] r_sbase [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_svalid, n_svalid, r_pvalid, n_pvalid;
    logic [MEMBERS-1:0] r_present, n_present, r_sent, n_sent;
    logic        r_emit, n_emit, r_rec, n_rec;
    logic [MIW-1:0] r_miss, n_miss, r_mi, n_mi;
    logic [PAW-1:0] r_w, n_w;
    logic [63:0] r_acc, n_acc;
    logic        r_ov, n_ov;
    logic [31:0] r_oseq, n_oseq;
    logic [63:0] r_oword, n_oword;
    logic        r_oend, n_oend, r_orun, n_orun;

    logic [63:0] r_pkt [PAYLOAD_WORDS];
    logic [63:0] r_mem [MEM_DEPTH];
    logic [63:0] r_par [PAR_DEPTH];
    logic [63:0] r_pkt_q, r_mem_q, r_par_q;

    logic        pkt_we;
    logic [PAW-1:0] pkt_wa;
    logic        mem_we, par_we, sbase_we;
    logic [MAW-1:0] mem_wa, mem_ra;
    logic [RAW-1:0] par_wa, par_ra;
    logic [63:0] mem_wd;

    logic        acc_in, out_free, hdr_ok, w_last;
    logic [GROUP_SIZE-1:0] grp, grp2, miss_v;
    logic        data_new, par_now;
    logic [MIW-1:0] miss_i;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign acc_in       = i_in_valid && o_in_ready;
    assign out_free     = !r_ov || i_out_ready;
    assign w_last       = (r_w == PAW'(PAYLOAD_WORDS - 1));
    assign o_out_valid  = r_ov;
    assign o_frame_seq  = r_oseq;
    assign o_frame_word = r_oword;
    assign o_frame_end  = r_oend;
    assign o_run_end    = r_orun;

    always_comb begin
        n_state = r_state;
        n_magic = r_magic;
        n_version = r_version;
        n_cnt = r_cnt;
        n_base = r_base;
        n_is_data = r_is_data;
        n_idx = r_idx;
        n_slot = r_slot;
        n_svalid = r_svalid;
        n_pvalid = r_pvalid;
        n_present = r_present;
        n_sent = r_sent;
        n_emit = r_emit;
        n_rec = r_rec;
        n_miss = r_miss;
        n_mi = r_mi;
        n_w = r_w;
        n_acc = r_acc;
        n_ov = r_ov && !i_out_ready;
        n_oseq = r_oseq;
        n_oword = r_oword;
        n_oend = r_oend;
        n_orun = r_orun;
        pkt_we = 1'b0;
        pkt_wa = r_cnt[PAW-1:0];
        mem_we = 1'b0;
        par_we = 1'b0;
        sbase_we = 1'b0;
        mem_wa = MAW'((32'(r_slot) * GROUP_SIZE + 32'(r_idx)) * PAYLOAD_WORDS + 32'(r_w));
        mem_ra = MAW'((32'(r_slot) * GROUP_SIZE + 32'(r_mi)) * PAYLOAD_WORDS + 32'(r_w));
        mem_wd = r_pkt_q;
        par_wa = RAW'(32'(r_slot) * PAYLOAD_WORDS + 32'(r_w));
        par_ra = par_wa;
        hdr_ok = 1'b0;
        grp = r_present[32'(r_slot) * GROUP_SIZE +: GROUP_SIZE];
        grp2 = grp;
        data_new = 1'b0;
        par_now = r_pvalid[r_slot] || !r_is_data;
        miss_v = '0;
        miss_i = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAGIC:   n_magic = i_cfg_data;
                CFG_VERSION: n_version = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (acc_in) begin
                    pkt_we = (r_cnt < BCW'(PAYLOAD_WORDS));
                    if (r_cnt <= BCW'(PAYLOAD_WORDS)) n_cnt = r_cnt + 1'b1;
                    if (i_last_word) begin
                        n_cnt = '0;
                        hdr_ok = ((r_cnt + 1'b1) == BCW'(PAYLOAD_WORDS))
                              && (i_wire_length == 12'(PACKET_LEN))
                              && (i_magic_field == r_magic)
                              && (i_version_field == r_version)
                              && (i_group_size_field == 8'(GROUP_SIZE))
                              && (((i_packet_kind == KIND_DATA)
                                   && (i_member_index < 8'(GROUP_SIZE)))
                               || ((i_packet_kind == KIND_PARITY)
                                   && (i_member_index == 8'(GROUP_SIZE))))
                              && ((i_base_seq % 32'(GROUP_SIZE)) == 32'd0);
                        if (hdr_ok) begin
                            n_base = i_base_seq;
                            n_is_data = (i_packet_kind == KIND_DATA);
                            n_idx = i_member_index[MIW-1:0];
                            n_slot = SW'((i_base_seq / 32'(GROUP_SIZE)) % 32'(SLOT_COUNT));
                            n_state = ST_SETUP;
                        end
                    end
                end
            end
            ST_SETUP: begin
                if (!r_svalid[r_slot] || (r_sbase[r_slot] != r_base)) begin
                    sbase_we = 1'b1;
                    n_svalid[r_slot] = 1'b1;
                    n_pvalid[r_slot] = 1'b0;
                    n_present[32'(r_slot) * GROUP_SIZE +: GROUP_SIZE] = '0;
                    n_sent[32'(r_slot) * GROUP_SIZE +: GROUP_SIZE] = '0;
                end
                n_state = ST_PLAN;
            end
            ST_PLAN: begin
                if (r_is_data) begin
                    data_new = !grp[r_idx];
                    grp2[r_idx] = 1'b1;
                end
                miss_v = ~grp2;
                for (int i = 0; i < GROUP_SIZE; i++) begin
                    if (miss_v[i]) miss_i = MIW'(i);
                end
                n_emit = data_new;
                n_rec = par_now && ($countones(miss_v) == 1);
                n_miss = miss_i;
                n_pvalid[r_slot] = par_now;
                n_present[32'(r_slot) * GROUP_SIZE +: GROUP_SIZE] =
                    grp2 | (n_rec ? miss_v : '0);
                n_sent[32'(r_slot) * GROUP_SIZE +: GROUP_SIZE] =
                    r_sent[32'(r_slot) * GROUP_SIZE +: GROUP_SIZE]
                    | (data_new ? (grp2 & ~grp) : '0) | (n_rec ? miss_v : '0);
                n_w = '0;
                n_mi = '0;
                if (data_new || !r_is_data) n_state = ST_CRD;
                else if (n_rec) n_state = ST_RRD;
                else n_state = ST_IDLE;
            end
            ST_CRD: begin
                n_state = ST_CWR;
            end
            ST_CWR: begin
                if (!r_emit || out_free) begin
                    mem_we = r_is_data;
                    par_we = !r_is_data;
                    if (r_emit) begin
                        n_ov = 1'b1;
                        n_oseq = r_base + 32'(r_idx);
                        n_oword = r_pkt_q;
                        n_oend = w_last;
                        n_orun = w_last && !r_rec;
                    end
                    n_w = r_w + 1'b1;
                    n_state = ST_CRD;
                    if (w_last) begin
                        n_w = '0;
                        n_state = r_rec ? ST_RRD : ST_IDLE;
                    end
                end
            end
            ST_RRD: begin
                n_state = ST_RACC;
            end
            ST_RACC: begin
                n_acc = ((r_mi == '0) ? r_par_q : r_acc)
                      ^ ((r_mi == r_miss) ? 64'd0 : r_mem_q);
                if (r_mi == MIW'(GROUP_SIZE - 1)) begin
                    n_state = ST_RWR;
                end else begin
                    n_mi = r_mi + 1'b1;
                    n_state = ST_RRD;
                end
            end
            ST_RWR: begin
                mem_wa = MAW'((32'(r_slot) * GROUP_SIZE + 32'(r_miss)) * PAYLOAD_WORDS
                              + 32'(r_w));
                mem_wd = r_acc;
                if (out_free) begin
                    mem_we = 1'b1;
                    n_ov = 1'b1;
                    n_oseq = r_base + 32'(r_miss);
                    n_oword = r_acc;
                    n_oend = w_last;
                    n_orun = w_last;
                    n_mi = '0;
                    n_w = r_w + 1'b1;
                    n_state = ST_RRD;
                    if (w_last) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_magic   <= MAGIC_RESET;
            r_version <= VERSION_RESET;
            r_cnt     <= '0;
            r_svalid  <= '0;
            r_pvalid  <= '0;
            r_present <= '0;
            r_sent    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_magic   <= n_magic;
            r_version <= n_version;
            r_cnt     <= n_cnt;
            r_svalid  <= n_svalid;
            r_pvalid  <= n_pvalid;
            r_present <= n_present;
            r_sent    <= n_sent;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base    <= n_base;
        r_is_data <= n_is_data;
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_emit    <= n_emit;
        r_rec     <= n_rec;
        r_miss    <= n_miss;
        r_mi      <= n_mi;
        r_w       <= n_w;
        r_acc     <= n_acc;
        r_oseq    <= n_oseq;
        r_oword   <= n_oword;
        r_oend    <= n_oend;
        r_orun    <= n_orun;
        if (sbase_we) r_sbase[r_slot] <= r_base;
    end

    // packet buffer
    always_ff @(posedge i_clk) begin
        if (pkt_we) r_pkt[pkt_wa] <= i_payload_word;
        r_pkt_q <= r_pkt[r_w];
    end

    // member store
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_mem_q <= r_mem[mem_ra];
    end

    // parity store
    always_ff @(posedge i_clk) begin
        if (par_we) r_par[par_wa] <= r_pkt_q;
        r_par_q <= r_par[par_ra];
    end

endmodule
